>>> sv/whro_pkg.sv
// whro_pkg: shared constants, types and ALU op codes for the half-recovery
// offset block. No dependencies; imported by every other file of the block.
`default_nettype none

package whro_pkg;

  // store geometry
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int HELD_W      = $clog2(STORE_DEPTH + 1);

  // field widths
  localparam int PRICE_W     = 32;
  localparam int HORIZON_W   = 10;
  localparam int OFFSET_W    = 10;
  localparam int K_W         = HORIZON_W;
  localparam int SUM_W       = PRICE_W + 1;
  localparam int EARLY_W     = (HELD_W > K_W) ? HELD_W : K_W;

  localparam logic [HORIZON_W-1:0] HORIZON_RESET = HORIZON_W'(30);

  // shared unit op codes
  typedef enum logic {
    ALU_ADD,
    ALU_GE
  } alu_op_t;

  // one stored bar
  typedef struct packed {
    logic [PRICE_W-1:0] low;
    logic [PRICE_W-1:0] close;
  } bar_t;

  // store write request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    bar_t              bar;
  } store_wr_t;

  // finished result from the sequencer
  typedef struct packed {
    logic           valid;
    logic [K_W-1:0] offset;
  } whro_res_t;

endpackage

`default_nettype wire

>>> sv/whro_if.sv
// whro_if: valid/ready channel interfaces for bar input and offset output.
// Depends on whro_pkg for field widths.
`default_nettype none

interface whro_in_if;
  import whro_pkg::*;
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] low_price;
  logic [PRICE_W-1:0] close_price;

  modport source (output valid, output low_price, output close_price, input ready);
  modport sink   (input valid, input low_price, input close_price, output ready);
endinterface

interface whro_out_if;
  import whro_pkg::*;
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] recovery_offset;

  modport source (output valid, output recovery_offset, input ready);
  modport sink   (input valid, input recovery_offset, output ready);
endinterface

`default_nettype wire

>>> sv/window_half_recovery_offset.sv
// window_half_recovery_offset: top level with horizon register, output
// register and the store, ALU and sequencer. Depends on whro_pkg and whro_if.
//
//  channel   dir  transfer when         payload
//  in_bar    in   valid && ready        low_price[31:0], close_price[31:0]
//  out_res   out  valid && ready        recovery_offset[9:0]
//  cfg       in   cfg_we                cfg_wdata[9:0] -> horizon
//
// For an item with a window of N bars (N = min(horizon, bars held - 1) + 1),
// both scans run over its N bars through the store's one read port, one entry
// per cycle, and the recovery scan ends early on its first hit. The first bar
// after reset gives no result. rst_n is synchronous and clears pointer, fill
// count and horizon (to 30); the store is not cleared.
// A waiting result sits in the output register, so the next bar is taken
// while out_res stalls; a second result waits in the sequencer.
`default_nettype none

module window_half_recovery_offset
  import whro_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  whro_in_if.sink                   in_bar,
  whro_out_if.source                out_res,
  input  wire logic                 cfg_we,
  input  wire logic [HORIZON_W-1:0] cfg_wdata
);

  logic [HORIZON_W-1:0] horizon_r;
  logic                 out_valid_r;
  logic [OFFSET_W-1:0]  out_off_r;
  logic                 res_take;
  whro_res_t            res;
  store_wr_t            st_wr;
  logic [ADDR_W-1:0]    st_raddr;
  bar_t                 st_rdata;
  bar_t                 in_data;
  alu_op_t              alu_op;
  logic [SUM_W-1:0]     alu_a;
  logic [SUM_W-1:0]     alu_b;
  logic [SUM_W-1:0]     alu_y;

  // horizon register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r <= HORIZON_RESET;
    end else if (cfg_we) begin
      horizon_r <= cfg_wdata;
    end
  end

  // output register, refilled when empty or being drained
  assign res_take = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res.valid;
    end
    if (res_take && res.valid) begin
      out_off_r <= OFFSET_W'(res.offset);
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.recovery_offset = out_off_r;

  assign in_data.low   = in_bar.low_price;
  assign in_data.close = in_bar.close_price;

  whro_store u_store (
    .clk   (clk),
    .wr    (st_wr),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  whro_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  whro_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bar.valid),
    .in_ready (in_bar.ready),
    .in_bar   (in_data),
    .horizon  (horizon_r),
    .res      (res),
    .res_take (res_take),
    .st_wr    (st_wr),
    .st_raddr (st_raddr),
    .st_rdata (st_rdata),
    .alu_op   (alu_op),
    .alu_a    (alu_a),
    .alu_b    (alu_b),
    .alu_y    (alu_y)
  );

endmodule

`default_nettype wire

>>> sv/whro_store.sv
// whro_store: ring store of bars, one write port and one registered read port.
// Depends on whro_pkg for geometry and the bar/write types.
`default_nettype none

module whro_store
  import whro_pkg::*;
(
  input  wire logic              clk,
  input  wire store_wr_t         wr,
  input  wire logic [ADDR_W-1:0] raddr,
  output bar_t                   rdata
);

  logic [PRICE_W-1:0] low_mem   [STORE_DEPTH];
  logic [PRICE_W-1:0] close_mem [STORE_DEPTH];
  bar_t               rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      low_mem[wr.addr]   <= wr.bar.low;
      close_mem[wr.addr] <= wr.bar.close;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r.low   <= low_mem[raddr];
    rdata_r.close <= close_mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> sv/whro_alu.sv
// whro_alu: shared add / unsigned compare unit used by every scan step.
// Depends on whro_pkg for operand width and op codes.
`default_nettype none

module whro_alu
  import whro_pkg::*;
(
  input  wire alu_op_t          op,
  input  wire logic [SUM_W-1:0] a,
  input  wire logic [SUM_W-1:0] b,
  output logic      [SUM_W-1:0] y
);

  // add for the doubled target, greater-or-equal for min and recovery checks
  always_comb begin
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_GE:  y = {{(SUM_W-1){1'b0}}, (a >= b)};
      default: y = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/whro_seq.sv
// whro_seq: sequencer that stores each bar and runs the low scan and the
// recovery scan through the store and the shared ALU. Depends on whro_pkg.
`default_nettype none

module whro_seq
  import whro_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire bar_t                 in_bar,
  input  wire logic [HORIZON_W-1:0] horizon,
  output whro_res_t                 res,
  input  wire logic                 res_take,
  output store_wr_t                 st_wr,
  output logic      [ADDR_W-1:0]    st_raddr,
  input  wire bar_t                 st_rdata,
  output alu_op_t                   alu_op,
  output logic      [SUM_W-1:0]     alu_a,
  output logic      [SUM_W-1:0]     alu_b,
  input  wire logic [SUM_W-1:0]     alu_y
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_LO_TAIL,
    ST_SUM,
    ST_CL,
    ST_CL_TAIL,
    ST_DONE
  } state_t;

  state_t              state_r,   state_nxt;
  logic [ADDR_W-1:0]   wp_r,      wp_nxt;
  logic [HELD_W-1:0]   held_r,    held_nxt;
  logic [ADDR_W-1:0]   start_r,   start_nxt;
  logic [ADDR_W-1:0]   pos_r,     pos_nxt;
  logic [K_W-1:0]      k_r,       k_nxt;
  logic [K_W-1:0]      kd_r,      kd_nxt;
  logic [K_W-1:0]      earlier_r, earlier_nxt;
  logic [PRICE_W-1:0]  lo_r,      lo_nxt;
  logic [PRICE_W-1:0]  cnew_r,    cnew_nxt;
  logic [SUM_W-1:0]    sum_r,     sum_nxt;
  logic                rd_vld_r,  rd_vld_nxt;
  logic [K_W-1:0]      off_r,     off_nxt;

  logic                accept;
  logic                ge;
  logic [HELD_W-1:0]   held_m1;
  logic [EARLY_W-1:0]  earlier_w;
  logic [ADDR_W-1:0]   earlier_a;
  logic [ADDR_W:0]     wrap_back;

  function automatic logic [ADDR_W-1:0] slot_fwd(input logic [ADDR_W-1:0] p);
    slot_fwd = (p == ADDR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_ready = (state_r == ST_IDLE);
  assign ge       = alu_y[0];

  // store ports: write on transfer, read wherever the scan points
  assign st_wr.we   = accept;
  assign st_wr.addr = wp_r;
  assign st_wr.bar  = in_bar;
  assign st_raddr   = pos_r;

  // window size: earlier bars limited by history held after this bar
  assign held_m1   = (held_r == HELD_W'(STORE_DEPTH)) ? HELD_W'(STORE_DEPTH - 1) : held_r;
  assign earlier_w = (EARLY_W'(horizon) < EARLY_W'(held_m1)) ? EARLY_W'(horizon)
                                                            : EARLY_W'(held_m1);
  assign earlier_a = ADDR_W'(earlier_w);
  assign wrap_back = {1'b0, wp_r} + (ADDR_W + 1)'(STORE_DEPTH) - {1'b0, earlier_a};

  // shared unit operand select
  always_comb begin
    unique case (state_r)
      ST_SUM: begin
        alu_op = ALU_ADD;
        alu_a  = {1'b0, lo_r};
        alu_b  = {1'b0, cnew_r};
      end
      ST_CL, ST_CL_TAIL: begin
        alu_op = ALU_GE;
        alu_a  = {st_rdata.close, 1'b0};
        alu_b  = sum_r;
      end
      default: begin
        alu_op = ALU_GE;
        alu_a  = {1'b0, st_rdata.low};
        alu_b  = {1'b0, lo_r};
      end
    endcase
  end

  // next-state logic
  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    held_nxt    = held_r;
    start_nxt   = start_r;
    pos_nxt     = pos_r;
    k_nxt       = k_r;
    kd_nxt      = kd_r;
    earlier_nxt = earlier_r;
    lo_nxt      = lo_r;
    cnew_nxt    = cnew_r;
    sum_nxt     = sum_r;
    rd_vld_nxt  = rd_vld_r;
    off_nxt     = off_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          wp_nxt      = slot_fwd(wp_r);
          held_nxt    = (held_r == HELD_W'(STORE_DEPTH)) ? held_r : held_r + 1'b1;
          earlier_nxt = K_W'(earlier_w);
          start_nxt   = (wp_r >= earlier_a) ? wp_r - earlier_a : wrap_back[ADDR_W-1:0];
          pos_nxt     = (wp_r >= earlier_a) ? wp_r - earlier_a : wrap_back[ADDR_W-1:0];
          k_nxt       = '0;
          lo_nxt      = '1;
          cnew_nxt    = in_bar.close;
          rd_vld_nxt  = 1'b0;
          // first bar after reset only fills the store
          state_nxt   = (held_r == '0) ? ST_IDLE : ST_LO;
        end
      end

      ST_LO: begin
        rd_vld_nxt = 1'b1;
        kd_nxt     = k_r;
        if (rd_vld_r && !ge) begin
          lo_nxt = st_rdata.low;
        end
        if (k_r == earlier_r) begin
          state_nxt = ST_LO_TAIL;
        end else begin
          pos_nxt = slot_fwd(pos_r);
          k_nxt   = k_r + 1'b1;
        end
      end

      ST_LO_TAIL: begin
        if (!ge) begin
          lo_nxt = st_rdata.low;
        end
        rd_vld_nxt = 1'b0;
        state_nxt  = ST_SUM;
      end

      ST_SUM: begin
        sum_nxt   = alu_y;
        pos_nxt   = start_r;
        k_nxt     = '0;
        state_nxt = ST_CL;
      end

      ST_CL: begin
        rd_vld_nxt = 1'b1;
        kd_nxt     = k_r;
        if (rd_vld_r && ge) begin
          // earliest recovering close found, stop the scan
          off_nxt    = kd_r;
          rd_vld_nxt = 1'b0;
          state_nxt  = ST_DONE;
        end else if (k_r == earlier_r) begin
          state_nxt = ST_CL_TAIL;
        end else begin
          pos_nxt = slot_fwd(pos_r);
          k_nxt   = k_r + 1'b1;
        end
      end

      ST_CL_TAIL: begin
        rd_vld_nxt = 1'b0;
        off_nxt    = ge ? kd_r : '0;
        state_nxt  = ST_DONE;
      end

      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wp_r     <= '0;
      held_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      held_r   <= held_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
    start_r   <= start_nxt;
    pos_r     <= pos_nxt;
    k_r       <= k_nxt;
    kd_r      <= kd_nxt;
    earlier_r <= earlier_nxt;
    lo_r      <= lo_nxt;
    cnew_r    <= cnew_nxt;
    sum_r     <= sum_nxt;
    off_r     <= off_nxt;
  end

  assign res.valid  = (state_r == ST_DONE);
  assign res.offset = off_r;

`ifndef NO_ASSERTIONS
  // scan index never runs past the window
  a_k_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LO || state_r == ST_CL) |-> (k_r <= earlier_r))
    else $error("scan index beyond window");

  // reported offset lies inside the window
  a_off_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (res.offset <= earlier_r))
    else $error("offset beyond window");

  // read data is only flagged while a scan is running
  a_rd_vld_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_LO || state_r == ST_LO_TAIL ||
                  state_r == ST_CL || state_r == ST_CL_TAIL))
    else $error("read valid outside scan");

  // a result not taken is held unchanged
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res_take) |=> (res.valid && $stable(off_r)))
    else $error("pending result lost");
`endif

endmodule

`default_nettype wire
